// File: rtl/core/ring_queue_with_front_insert_core_macros.svh
// ----------------------------------------------------------------------------
// Ring queue assertion macros
// Shared concurrent assertion wrappers, clocked on clk.
// ----------------------------------------------------------------------------
`ifndef RING_QUEUE_WITH_FRONT_INSERT_CORE_MACROS_SVH
`define RING_QUEUE_WITH_FRONT_INSERT_CORE_MACROS_SVH

// Checked outside reset only
`define RQFI_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every edge, reset included
`define RQFI_ASSERT_RST(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/core/rqfi_pkg.sv
// ----------------------------------------------------------------------------
// Ring queue package
// Operation codes, status codes, controller states and fixed field widths.
// ----------------------------------------------------------------------------
package rqfi_pkg;

  localparam int FUNC_W   = 3;
  localparam int STATUS_W = 2;
  // capacity register and fill level share this width
  localparam int CAP_W    = 5;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_SEND_BACK  = 3'd0,
    FUNC_SEND_FRONT = 3'd1,
    FUNC_RECEIVE    = 3'd2,
    FUNC_PEEK       = 3'd3,
    FUNC_RESET      = 3'd4
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic {
    S_IDLE,
    S_RESULT
  } state_t;

endpackage

// File: rtl/core/rqfi_if.sv
// ----------------------------------------------------------------------------
// Ring queue channel interfaces
// Request channel (operation and item) and response channel (status, item,
// fill level), each with valid/ready.
// ----------------------------------------------------------------------------
interface rqfi_req_if #(
  parameter int ITEM_BITS = 32
);
  logic                         valid;
  logic                         ready;
  logic [rqfi_pkg::FUNC_W-1:0]  func;
  logic [ITEM_BITS-1:0]         item_in;

  modport source (output valid, output func, output item_in, input ready);
  modport sink   (input valid, input func, input item_in, output ready);
endinterface

interface rqfi_rsp_if #(
  parameter int ITEM_BITS = 32
);
  logic                          valid;
  logic                          ready;
  logic [rqfi_pkg::STATUS_W-1:0] status;
  logic [ITEM_BITS-1:0]          item_out;
  logic [rqfi_pkg::CAP_W-1:0]    fill_level;

  modport source (output valid, output status, output item_out, output fill_level,
                  input ready);
  modport sink   (input valid, input status, input item_out, input fill_level,
                  output ready);
endinterface

// File: rtl/core/ring_queue_with_front_insert_core.sv
// Flow: a request transaction reads the item store and enters the result state;
//   the registered read data then loads the response register, which offers it.
// A request is not taken until the previous result has loaded the response
//   register.
// A new request is taken while the previous response still waits.
// Reset (rst, synchronous): queue empty, capacity min(16, DEPTH), no response
//   pending; store contents are left as they are.
// ----------------------------------------------------------------------------
// Ring queue with front insert
// Circular queue of items with append, front insert, receive, peek and
// clear; head, tail and count in registers, items in a synchronous store.
// ----------------------------------------------------------------------------
`include "ring_queue_with_front_insert_core_macros.svh"

module ring_queue_with_front_insert_core #(
  parameter int DEPTH     = 16,
  parameter int ITEM_BITS = 32
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [rqfi_pkg::CAP_W-1:0] cfg_wdata,
  rqfi_req_if.sink                   req,
  rqfi_rsp_if.source                 rsp
);

  localparam int CAP_W     = rqfi_pkg::CAP_W;
  localparam int PTR_W     = $clog2(DEPTH);
  localparam int CMP_W     = ((PTR_W > CAP_W) ? PTR_W : CAP_W) + 1;
  localparam int CAP_RESET = (DEPTH < 16) ? DEPTH : 16;

  // controller and queue state
  rqfi_pkg::state_t  state, state_next;
  logic [PTR_W-1:0]  head, head_next;
  logic [PTR_W-1:0]  tail, tail_next;
  logic [CAP_W-1:0]  count, count_next;
  logic [CAP_W-1:0]  cap_eff, cap_cfg;

  // pending result, captured at request transaction
  rqfi_pkg::status_t pend_status, op_status;
  logic [CAP_W-1:0]  pend_fill;
  logic              pend_read;

  // response register
  logic                 out_valid;
  rqfi_pkg::status_t    out_status;
  logic [ITEM_BITS-1:0] out_item;
  logic [CAP_W-1:0]     out_fill;

  // store access
  logic                 wr_en, op_wr, rd_en, op_rd;
  logic [PTR_W-1:0]     wr_addr;
  logic [ITEM_BITS-1:0] rd_data;

  logic              in_fire, load_out;
  rqfi_pkg::func_t   func_code;
  logic [CMP_W-1:0]  head_inc, tail_inc, cap_m1;
  logic [PTR_W-1:0]  head_wrap, tail_wrap, head_dec;
  logic              has_room, not_empty;

  // terms for the checks
  logic              chk_ptrs, chk_append, chk_result, chk_clean;

  assign in_fire   = req.valid & req.ready;
  assign func_code = rqfi_pkg::func_t'(req.func);

  // capacity from the write data: 0 acts as 1, above DEPTH acts as DEPTH
  always_comb begin
    if (cfg_wdata == '0) begin
      cap_cfg = CAP_W'(1);
    end else if (int'(cfg_wdata) > DEPTH) begin
      cap_cfg = CAP_W'(DEPTH);
    end else begin
      cap_cfg = cfg_wdata;
    end
  end

  // wrapped pointer arithmetic
  assign head_inc  = CMP_W'(head) + CMP_W'(1);
  assign tail_inc  = CMP_W'(tail) + CMP_W'(1);
  assign cap_m1    = CMP_W'(cap_eff) - CMP_W'(1);
  assign head_wrap = (head_inc >= CMP_W'(cap_eff)) ? '0 : PTR_W'(head_inc);
  assign tail_wrap = (tail_inc >= CMP_W'(cap_eff)) ? '0 : PTR_W'(tail_inc);
  assign head_dec  = (head == '0) ? PTR_W'(cap_m1) : head - PTR_W'(1);
  assign has_room  = count < cap_eff;
  assign not_empty = count != '0;

  // operation decode
  always_comb begin
    head_next  = head;
    tail_next  = tail;
    count_next = count;
    op_status  = rqfi_pkg::ST_OK;
    op_wr      = 1'b0;
    op_rd      = 1'b0;
    wr_addr    = tail;
    unique case (func_code) inside
      rqfi_pkg::FUNC_SEND_BACK: begin
        if (has_room) begin
          op_wr      = 1'b1;
          tail_next  = tail_wrap;
          count_next = count + CAP_W'(1);
        end else begin
          op_status  = rqfi_pkg::ST_FULL;
        end
      end
      rqfi_pkg::FUNC_SEND_FRONT: begin
        if (has_room) begin
          op_wr      = 1'b1;
          wr_addr    = head_dec;
          head_next  = head_dec;
          count_next = count + CAP_W'(1);
        end else begin
          op_status  = rqfi_pkg::ST_FULL;
        end
      end
      rqfi_pkg::FUNC_RECEIVE, rqfi_pkg::FUNC_PEEK: begin
        if (not_empty) begin
          op_rd = 1'b1;
          if (func_code == rqfi_pkg::FUNC_RECEIVE) begin
            head_next  = head_wrap;
            count_next = count - CAP_W'(1);
          end
        end else begin
          op_status = rqfi_pkg::ST_EMPTY;
        end
      end
      rqfi_pkg::FUNC_RESET: begin
        head_next  = '0;
        tail_next  = '0;
        count_next = '0;
      end
      default: begin
      end
    endcase
  end

  assign wr_en = in_fire & op_wr;
  assign rd_en = in_fire & op_rd;

  // one operation at a time: a write and a read never share a cycle
  rqfi_store #(
    .DEPTH     (DEPTH),
    .ITEM_BITS (ITEM_BITS)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (req.item_in),
    .rd_en   (rd_en),
    .rd_addr (head),
    .rd_data (rd_data)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      rqfi_pkg::S_IDLE: begin
        if (in_fire) begin
          state_next = rqfi_pkg::S_RESULT;
        end
      end
      rqfi_pkg::S_RESULT: begin
        if (load_out) begin
          state_next = rqfi_pkg::S_IDLE;
        end
      end
      default: state_next = rqfi_pkg::S_IDLE;
    endcase
  end

  // controller outputs
  always_comb begin
    req.ready = 1'b0;
    load_out  = 1'b0;
    unique case (state)
      rqfi_pkg::S_IDLE:   req.ready = 1'b1;
      rqfi_pkg::S_RESULT: load_out  = ~out_valid | rsp.ready;
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= rqfi_pkg::S_IDLE;
      head      <= '0;
      tail      <= '0;
      count     <= '0;
      cap_eff   <= CAP_W'(CAP_RESET);
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        cap_eff <= cap_cfg;
        head    <= '0;
        tail    <= '0;
        count   <= '0;
      end else if (in_fire) begin
        head  <= head_next;
        tail  <= tail_next;
        count <= count_next;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      pend_status <= op_status;
      pend_fill   <= count_next;
      pend_read   <= op_rd;
    end
    if (load_out) begin
      out_status <= pend_status;
      out_item   <= pend_read ? rd_data : '0;
      out_fill   <= pend_fill;
    end
  end

  assign rsp.valid      = out_valid;
  assign rsp.status     = out_status;
  assign rsp.item_out   = out_item;
  assign rsp.fill_level = out_fill;

  // checks
  assign chk_ptrs   = (CMP_W'(head) < CMP_W'(cap_eff)) && (CMP_W'(tail) < CMP_W'(cap_eff));
  assign chk_append = in_fire && !cfg_we && func_code == rqfi_pkg::FUNC_SEND_BACK && has_room;
  assign chk_result = state == rqfi_pkg::S_RESULT && !req.ready;
  assign chk_clean  = state == rqfi_pkg::S_IDLE && !out_valid && count == '0;

  `RQFI_ASSERT(a_count_in_cap, count <= cap_eff, "item count above capacity")
  `RQFI_ASSERT(a_ptr_in_cap, chk_ptrs, "pointer past wrap point")
  `RQFI_ASSERT(a_append_count, chk_append |=> count == $past(count) + CAP_W'(1), "append count")
  `RQFI_ASSERT(a_accept_result, in_fire |=> chk_result, "request not followed by result phase")
  `RQFI_ASSERT_RST(a_reset_clean, $past(rst) |-> chk_clean, "reset left state behind")

endmodule

// File: rtl/core/rqfi_store.sv
// ----------------------------------------------------------------------------
// Ring queue item store
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module rqfi_store #(
  parameter int DEPTH     = 16,
  parameter int ITEM_BITS = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [ITEM_BITS-1:0]     wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [ITEM_BITS-1:0]     rd_data
);

  logic [ITEM_BITS-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
